// ===== rtl/core/mq_pkg.sv =====
package mq_pkg;

    // Field widths of the stream payloads.
    localparam int unsigned FieldWidth = 32;
    localparam int unsigned OccWidth   = 5;

    typedef enum logic [1:0] {
        OP_QUERY = 2'd0,
        OP_PUSH  = 2'd1,
        OP_POP   = 2'd2,
        OP_CLEAR = 2'd3
    } t_mq_op;

    // Per-cycle command broadcast to every cell, already qualified by the
    // input transfer and the error checks.
    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } t_mq_ctrl;

    typedef struct packed {
        logic                  err;
        logic [OccWidth-1:0]   occupancy;
        logic [FieldWidth-1:0] min_val;
        logic [FieldWidth-1:0] data;
    } t_mq_result;

endpackage

// ===== rtl/core/min_queue.sv =====
// Minimum-tracking FIFO queue.
// Slave channel: tuser carries the operation (query, push, pop, clear) and
// tdata the value to push. Master channel: one result per input transfer,
// tdata carrying the oldest or popped value, the minimum of the held values
// and the occupancy; tuser carries the error flag (push when full, pop when
// empty).
// The queue is a row of DEPTH cells, the oldest entry in cell 0. Each cell
// holds a value and the minimum of itself and all newer entries; a pop shifts
// the whole row one cell toward the head, a push lands in the first empty
// cell and lowers the stored minimum of every occupied cell in parallel.
// Throughput is one item per cycle while o_s_tready is high.
// Each result is registered in the output buffer before it shows on o_m_tvalid.
// Results go through a two-entry output buffer; input transfers continue
// while one result waits, and o_s_tready falls only when both entries are
// full because the receiver stalls.
// Reset empties the queue and the output buffer; cell contents are not
// cleared, only their occupied flags.
module min_queue
    import mq_pkg::*;
#(
    parameter int unsigned DEPTH       = 16,
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] push_value
    input  logic [1:0]  i_s_tuser,   // [1:0] opcode
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [71:0] o_m_tdata,   // [31:0] data_out, [63:32] min_out, [68:64] occupancy
    output logic [0:0]  o_m_tuser    // [0] error_flag
);

    localparam int unsigned CntWidth = $clog2(DEPTH + 1);

    logic                          w_accept;
    t_mq_op                        w_op;
    t_mq_ctrl                      w_ctrl;
    logic signed [VALUE_WIDTH-1:0] w_push_value;
    logic                          w_full;
    logic                          w_empty;
    logic                          w_err;
    logic                          w_out_ready;
    t_mq_result                    w_result;
    t_mq_result                    w_out_result;
    logic [CntWidth-1:0]           r_count;
    logic [CntWidth-1:0]           n_count;

    logic                          w_valid     [DEPTH];
    logic signed [VALUE_WIDTH-1:0] w_value     [DEPTH];
    logic signed [VALUE_WIDTH-1:0] w_min       [DEPTH];
    logic                          w_nxt_valid [DEPTH];
    logic signed [VALUE_WIDTH-1:0] w_nxt_value [DEPTH];
    logic signed [VALUE_WIDTH-1:0] w_nxt_min   [DEPTH];

    assign o_s_tready   = w_out_ready;
    assign w_accept     = i_s_tvalid && w_out_ready;
    assign w_op         = t_mq_op'(i_s_tuser);
    assign w_push_value = VALUE_WIDTH'(signed'(i_s_tdata));
    assign w_full       = w_valid[DEPTH-1];
    assign w_empty      = !w_valid[0];

    always_comb begin
        w_ctrl = '0;
        w_err  = 1'b0;
        case (w_op)
            OP_QUERY: begin
                w_err = 1'b0;
            end
            OP_PUSH: begin
                w_err       = w_full;
                w_ctrl.push = w_accept && !w_full;
            end
            OP_POP: begin
                w_err      = w_empty;
                w_ctrl.pop = w_accept && !w_empty;
            end
            OP_CLEAR: begin
                w_ctrl.clear = w_accept;
            end
            default: begin
                w_err = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_count = r_count;
        if (w_ctrl.clear) begin
            n_count = '0;
        end else if (w_ctrl.push) begin
            n_count = r_count + CntWidth'(1);
        end else if (w_ctrl.pop) begin
            n_count = r_count - CntWidth'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic                          w_prev_valid;
        logic                          w_next_valid;
        logic signed [VALUE_WIDTH-1:0] w_next_value;
        logic signed [VALUE_WIDTH-1:0] w_next_min;

        if (g == 0) begin : g_head
            assign w_prev_valid = 1'b1;
        end else begin : g_body
            assign w_prev_valid = w_valid[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_next_valid = 1'b0;
            assign w_next_value = '0;
            assign w_next_min   = '0;
        end else begin : g_inner
            assign w_next_valid = w_valid[g+1];
            assign w_next_value = w_value[g+1];
            assign w_next_min   = w_min[g+1];
        end

        mq_cell #(
            .VALUE_WIDTH(VALUE_WIDTH)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_push_value (w_push_value),
            .i_prev_valid (w_prev_valid),
            .i_next_valid (w_next_valid),
            .i_next_value (w_next_value),
            .i_next_min   (w_next_min),
            .o_valid      (w_valid[g]),
            .o_value      (w_value[g]),
            .o_min        (w_min[g]),
            .o_nxt_valid  (w_nxt_valid[g]),
            .o_nxt_value  (w_nxt_value[g]),
            .o_nxt_min    (w_nxt_min[g])
        );
    end

    // The result reflects the head cell after this operation, except that a
    // pop reports the value leaving the head.
    always_comb begin
        w_result           = '0;
        w_result.err       = w_err && (w_op != OP_CLEAR);
        w_result.occupancy = OccWidth'(n_count);
        if (w_ctrl.pop) begin
            w_result.data = FieldWidth'(w_value[0]);
        end else if (w_nxt_valid[0]) begin
            w_result.data = FieldWidth'(w_nxt_value[0]);
        end
        if (w_nxt_valid[0]) begin
            w_result.min_val = FieldWidth'(w_nxt_min[0]);
        end
    end

    mq_out_buf u_out_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .i_result (w_result),
        .o_ready  (w_out_ready),
        .o_valid  (o_m_tvalid),
        .o_result (w_out_result),
        .i_ready  (i_m_tready)
    );

    assign o_m_tdata = {3'b000, w_out_result.occupancy, w_out_result.min_val,
                        w_out_result.data};
    assign o_m_tuser = w_out_result.err;

endmodule

// ===== rtl/core/mq_cell.sv =====
module mq_cell
    import mq_pkg::*;
#(
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_mq_ctrl                      i_ctrl,
    input  logic signed [VALUE_WIDTH-1:0] i_push_value,
    input  logic                          i_prev_valid,
    input  logic                          i_next_valid,
    input  logic signed [VALUE_WIDTH-1:0] i_next_value,
    input  logic signed [VALUE_WIDTH-1:0] i_next_min,
    output logic                          o_valid,
    output logic signed [VALUE_WIDTH-1:0] o_value,
    output logic signed [VALUE_WIDTH-1:0] o_min,
    output logic                          o_nxt_valid,
    output logic signed [VALUE_WIDTH-1:0] o_nxt_value,
    output logic signed [VALUE_WIDTH-1:0] o_nxt_min
);

    logic                          r_valid;
    logic signed [VALUE_WIDTH-1:0] r_value;
    logic signed [VALUE_WIDTH-1:0] r_min;
    logic                          n_valid;
    logic signed [VALUE_WIDTH-1:0] n_value;
    logic signed [VALUE_WIDTH-1:0] n_min;
    logic                          w_tail;

    // The first empty cell (cell 0, or one behind an occupied cell) receives a pushed value.
    assign w_tail = i_prev_valid && !r_valid;

    always_comb begin
        n_valid = r_valid;
        n_value = r_value;
        n_min   = r_min;
        if (i_ctrl.clear) begin
            n_valid = 1'b0;
        end else if (i_ctrl.pop) begin
            // Everything moves one cell toward the head; the neighbor's
            // suffix minimum is already correct for its new place.
            n_valid = i_next_valid;
            n_value = i_next_value;
            n_min   = i_next_min;
        end else if (i_ctrl.push) begin
            if (w_tail) begin
                n_valid = 1'b1;
                n_value = i_push_value;
                n_min   = i_push_value;
            end else if (r_valid && (i_push_value < r_min)) begin
                n_min = i_push_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_value <= n_value;
        r_min   <= n_min;
    end

    assign o_valid     = r_valid;
    assign o_value     = r_value;
    assign o_min       = r_min;
    assign o_nxt_valid = n_valid;
    assign o_nxt_value = n_value;
    assign o_nxt_min   = n_min;

endmodule

// ===== rtl/core/mq_out_buf.sv =====
module mq_out_buf
    import mq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_mq_result i_result,
    output logic       o_ready,
    output logic       o_valid,
    output t_mq_result o_result,
    input  logic       i_ready
);

    logic       r_out_valid;
    logic       r_skid_valid;
    t_mq_result r_out;
    t_mq_result r_skid;
    logic       w_take;
    logic       w_load;

    assign o_ready = !r_skid_valid;
    assign w_take  = r_out_valid && i_ready;
    assign w_load  = i_valid && !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_load) begin
            if (!r_out_valid || w_take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (w_take) begin
            // The skid entry, if any, moves up behind the transfer.
            r_out_valid  <= r_skid_valid;
            r_skid_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            if (!r_out_valid || w_take) begin
                r_out <= i_result;
            end else begin
                r_skid <= i_result;
            end
        end else if (w_take && r_skid_valid) begin
            r_out <= r_skid;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

// ===== rtl/core/mq_checker.sv =====
module mq_checker #(
    parameter int unsigned DEPTH = 16
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [71:0] o_m_tdata,
    input logic [0:0]  o_m_tuser
);

    localparam logic [4:0] FullOcc = 5'(DEPTH);

    // No result may appear right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser))
        else $error("stalled result changed");

    // An empty queue reports a zero minimum. The value field must be zero when the error flag
    // is set; a pop that took the last entry reports that entry, so it is not checked then.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[68:64] == 5'd0) |->
            (o_m_tdata[63:32] == 32'd0)
            && (!o_m_tuser[0] || (o_m_tdata[31:0] == 32'd0)))
        else $error("empty queue reports nonzero value");

    // An error only arises from a full push or an empty pop.
    a_err_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |->
            (o_m_tdata[68:64] == 5'd0) || (o_m_tdata[68:64] == FullOcc))
        else $error("error flag with partial occupancy");

endmodule

bind min_queue mq_checker #(
    .DEPTH(DEPTH)
) u_mq_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
